// ===== hdl/soa_pkg.sv =====
// soa_pkg: shared constants, size class table and codes for the slab object allocator
// no dependencies
package soa_pkg;

   localparam int NUM_PAGES   = 64;
   localparam int PAGE_W      = 6;
   localparam int LINK_W      = 7;
   localparam logic [LINK_W-1:0] LINK_NULL = 7'd64;
   localparam int DATA_BYTES  = 4000;
   localparam int NUM_CLASSES = 25;
   localparam int CLASS_W     = 5;
   localparam int MAX_SLOTS   = 512;
   localparam int SLOT_W      = 9;
   localparam int ITEMS_W     = 10;
   localparam int WORDS       = 8;
   localparam int WORD_W      = 3;
   localparam int SIZE_W      = 8;
   localparam int OFFSET_W    = 12;
   localparam int STATUS_W    = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd3;

   localparam logic [1:0] LINK_NONE    = 2'd0;
   localparam logic [1:0] LINK_UNLINK  = 2'd1;
   localparam logic [1:0] LINK_ADDHEAD = 2'd2;

   // slots per page for each class, zero marks a class that does not exist
   localparam logic [ITEMS_W-1:0] ITEMS_TABLE [32] = '{
      10'd500, 10'd250, 10'd166, 10'd125, 10'd100, 10'd83, 10'd71, 10'd62,
      10'd55,  10'd50,  10'd45,  10'd41,  10'd38,  10'd35, 10'd33, 10'd31,
      10'd29,  10'd27,  10'd26,  10'd25,  10'd23,  10'd22, 10'd21, 10'd20,
      10'd20,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0,  10'd0,  10'd0
   };

endpackage

// ===== hdl/soa_if.sv =====
// soa_req_if and soa_rsp_if: valid/ready channels for requests and results
// depends on soa_pkg
interface soa_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [soa_pkg::SIZE_W-1:0] size_bytes;
   logic [soa_pkg::PAGE_W-1:0] page_index;
   logic [soa_pkg::OFFSET_W-1:0] byte_offset;
   modport source (output valid, mode, size_bytes, page_index, byte_offset, input ready);
   modport sink (input valid, mode, size_bytes, page_index, byte_offset, output ready);
endinterface

interface soa_rsp_if;
   logic valid;
   logic ready;
   logic [soa_pkg::STATUS_W-1:0] status;
   logic [soa_pkg::PAGE_W-1:0] out_page;
   logic [soa_pkg::OFFSET_W-1:0] out_offset;
   modport source (output valid, status, out_page, out_offset, input ready);
   modport sink (input valid, status, out_page, out_offset, output ready);
endinterface

// ===== hdl/soa_div.sv =====
// soa_div: restoring divider, one quotient bit per cycle, for free offset checks
// depends on soa_pkg
module soa_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [soa_pkg::OFFSET_W-1:0] dividend,
   input  logic [7:0] divisor,
   output logic done,
   output logic [soa_pkg::OFFSET_W-1:0] quotient,
   output logic [7:0] remainder
);
   logic busy_ff;
   logic done_ff;
   logic [3:0] cnt_ff;
   logic [soa_pkg::OFFSET_W-1:0] quo_ff;
   logic [7:0] rem_ff;
   logic [7:0] dsr_ff;
   logic [8:0] trial;

   assign trial = {rem_ff, quo_ff[soa_pkg::OFFSET_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         // dividend bits shift out the top while quotient bits shift in
         if (trial >= {1'b0, dsr_ff}) begin
            rem_ff <= 8'(trial - {1'b0, dsr_ff});
            quo_ff <= {quo_ff[soa_pkg::OFFSET_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[7:0];
            quo_ff <= {quo_ff[soa_pkg::OFFSET_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 4'd1;
         if (cnt_ff == 4'(soa_pkg::OFFSET_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule

// ===== hdl/slab_object_allocator_top.sv =====
// slab_object_allocator_top: slab allocator sequencer with bitmap and page link memories
// depends on soa_pkg, soa_if, soa_div
//
// One request at a time. Allocate from a listed page decodes, reads the page metadata,
// then reads and checks one bitmap word per step (one to nine 64-bit words, one read each
// through the bitmap memory's read port) and commits, with a link step more when the
// page fills and leaves its list; taking a fresh pool page adds the clear of its eight
// bitmap words. Free waits on the 12-step offset divider. Size errors answer from decode.
// A finished result sits in an output register while the next request is taken. No
// clearing pass after reset: page state is written when a page is taken.
module slab_object_allocator_top (
   input logic clock,
   input logic reset,
   soa_req_if.sink req,
   soa_rsp_if.source rsp
);
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_NEWPG     = 4'd2;
   localparam logic [3:0] S_META_CAP  = 4'd3;
   localparam logic [3:0] S_SCAN_INIT = 4'd4;
   localparam logic [3:0] S_SCAN_RD   = 4'd5;
   localparam logic [3:0] S_SCAN_CHK  = 4'd6;
   localparam logic [3:0] S_FREE_WAIT = 4'd7;
   localparam logic [3:0] S_FREE_RD   = 4'd8;
   localparam logic [3:0] S_FREE_BIT  = 4'd9;
   localparam logic [3:0] S_COMMIT    = 4'd10;
   localparam logic [3:0] S_LINK      = 4'd11;
   localparam logic [3:0] S_DONE      = 4'd12;

   localparam int PW = soa_pkg::PAGE_W;
   localparam int LW = soa_pkg::LINK_W;
   localparam int SW = soa_pkg::SLOT_W;
   localparam int IW = soa_pkg::ITEMS_W;
   localparam int CNT_W = 2 * SW + soa_pkg::CLASS_W;
   localparam int WORD_W_L = soa_pkg::WORD_W;

   // memories
   logic [63:0] bm_mem [soa_pkg::NUM_PAGES * soa_pkg::WORDS];
   logic [CNT_W-1:0] cnt_mem [soa_pkg::NUM_PAGES];
   logic [LW-1:0] next_mem [soa_pkg::NUM_PAGES];
   logic [LW-1:0] prev_mem [soa_pkg::NUM_PAGES];

   logic [3:0] state_ff;
   logic rsp_valid_ff;
   logic [soa_pkg::NUM_PAGES-1:0] busy_ff;
   logic [LW-1:0] head_ff [soa_pkg::NUM_CLASSES];

   logic mode_ff;
   logic [soa_pkg::SIZE_W-1:0] size_ff;
   logic [PW-1:0] pidx_ff;
   logic [soa_pkg::OFFSET_W-1:0] off_ff;
   logic [8:0] bytes_ff;
   logic [soa_pkg::CLASS_W-1:0] cls_ff;
   logic [IW-1:0] items_ff;

   logic [PW-1:0] p_ff;
   logic [SW-1:0] used_ff, guess_ff, used_new_ff, guess_new_ff, slot_ff;
   logic [LW-1:0] pr_ff, nx_ff, h_ff;
   logic [1:0] op_ff;
   logic [WORD_W_L-1:0] clr_ff;
   logic [WORD_W_L-1:0] w_ff;
   logic [5:0] lo_ff;
   logic [3:0] k_ff;
   logic first_ff;
   logic [63:0] word_ff;

   logic [soa_pkg::STATUS_W-1:0] res_status_ff;
   logic [PW-1:0] res_page_ff;
   logic [soa_pkg::OFFSET_W-1:0] res_offset_ff;

   logic [63:0] bm_q;
   logic [CNT_W-1:0] cnt_q;
   logic [LW-1:0] next_q, prev_q;

   // memory port controls
   logic bm_we, bm_re;
   logic [PW+WORD_W_L-1:0] bm_waddr, bm_raddr;
   logic [63:0] bm_wdata;
   logic meta_re, cnt_we, next_we, prev_we;
   logic [PW-1:0] meta_raddr, next_waddr, prev_waddr;
   logic [LW-1:0] next_wdata, prev_wdata;

   // request decode
   logic [8:0] req_bytes;
   logic [soa_pkg::CLASS_W-1:0] req_cls;

   // helpers
   logic [LW-1:0] head_cur;
   logic free_found;
   logic [PW-1:0] free_page;
   logic [63:0] avail;
   logic word_found;
   logic [5:0] word_pos;
   logic [4:0] nw;
   logic [SW-1:0] scan_slot;
   logic [SW-1:0] start_guess;
   logic [17:0] prod;

   logic div_start, div_done;
   logic [soa_pkg::OFFSET_W-1:0] div_quo;
   logic [7:0] div_rem;

   soa_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(off_ff), .divisor(bytes_ff[7:0]),
      .done(div_done), .quotient(div_quo), .remainder(div_rem)
   );

   assign req_bytes = 9'((10'({2'b0, req.size_bytes}) + 10'd7) & ~10'd7);
   assign req_cls = 5'(req_bytes[8:3] - 6'd1);

   assign head_cur = head_ff[cls_ff];
   assign nw = 5'((11'({1'b0, items_ff}) + 11'd63) >> 6);
   assign start_guess = ({1'b0, guess_ff} >= items_ff) ? '0 : guess_ff;
   assign scan_slot = {w_ff, word_pos};
   assign prod = 18'(scan_slot) * 18'(bytes_ff);

   // lowest free pool page
   always_comb begin
      free_found = 1'b0;
      free_page = '0;
      for (int i = soa_pkg::NUM_PAGES - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_page = PW'(i);
         end
      end
   end

   // free slots of the current bitmap word that the scan may take
   always_comb begin
      for (int j = 0; j < 64; j++) begin
         avail[j] = !bm_q[j] && (IW'({w_ff, 6'(j)}) < items_ff)
                    && (!first_ff || 6'(j) >= lo_ff);
      end
      word_found = 1'b0;
      word_pos = '0;
      for (int j = 63; j >= 0; j--) begin
         if (avail[j]) begin
            word_found = 1'b1;
            word_pos = 6'(j);
         end
      end
   end

   always_comb begin
      bm_we = 1'b0; bm_waddr = {p_ff, slot_ff[SW-1:6]}; bm_wdata = word_ff;
      bm_re = 1'b0; bm_raddr = {p_ff, w_ff};
      meta_re = 1'b0; meta_raddr = mode_ff ? pidx_ff : head_cur[PW-1:0];
      cnt_we = 1'b0;
      next_we = 1'b0; next_waddr = p_ff; next_wdata = soa_pkg::LINK_NULL;
      prev_we = 1'b0; prev_waddr = p_ff; prev_wdata = soa_pkg::LINK_NULL;
      div_start = 1'b0;
      case (state_ff)
         S_DECODE: begin
            meta_re = 1'b1;
            div_start = mode_ff && (items_ff != '0);
         end
         S_NEWPG: begin
            bm_we = 1'b1;
            bm_waddr = {p_ff, clr_ff};
            bm_wdata = '0;
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         S_SCAN_RD: bm_re = 1'b1;
         S_FREE_RD: begin
            bm_re = 1'b1;
            bm_raddr = {p_ff, slot_ff[SW-1:6]};
         end
         S_COMMIT: begin
            bm_we = 1'b1;
            cnt_we = 1'b1;
            if (op_ff != soa_pkg::LINK_NONE) begin
               next_we = 1'b1;
               prev_we = 1'b1;
               if (op_ff == soa_pkg::LINK_ADDHEAD) next_wdata = head_cur;
            end
         end
         S_LINK: begin
            if (op_ff == soa_pkg::LINK_UNLINK) begin
               next_we = (pr_ff != soa_pkg::LINK_NULL);
               next_waddr = pr_ff[PW-1:0];
               next_wdata = nx_ff;
               prev_we = (nx_ff != soa_pkg::LINK_NULL);
               prev_waddr = nx_ff[PW-1:0];
               prev_wdata = pr_ff;
            end else begin
               prev_we = (h_ff != soa_pkg::LINK_NULL);
               prev_waddr = h_ff[PW-1:0];
               prev_wdata = {1'b0, p_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      if (bm_re) bm_q <= bm_mem[bm_raddr];
      if (cnt_we) cnt_mem[p_ff] <= {used_new_ff, guess_new_ff, cls_ff};
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      if (meta_re) begin
         cnt_q <= cnt_mem[meta_raddr];
         next_q <= next_mem[meta_raddr];
         prev_q <= prev_mem[meta_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         busy_ff <= '0;
         for (int c = 0; c < soa_pkg::NUM_CLASSES; c++) head_ff[c] <= soa_pkg::LINK_NULL;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  mode_ff <= req.mode;
                  size_ff <= req.size_bytes;
                  pidx_ff <= req.page_index;
                  off_ff <= req.byte_offset;
                  bytes_ff <= req_bytes;
                  cls_ff <= req_cls;
                  items_ff <= soa_pkg::ITEMS_TABLE[req_cls];
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               res_status_ff <= soa_pkg::STATUS_OK;
               res_page_ff <= '0;
               res_offset_ff <= '0;
               if (size_ff == '0 || items_ff == '0
                   || bytes_ff[8:3] > 6'(soa_pkg::NUM_CLASSES)) begin
                  res_status_ff <= soa_pkg::STATUS_BAD_SIZE;
                  state_ff <= S_DONE;
               end else if (mode_ff) begin
                  state_ff <= S_FREE_WAIT;
               end else if (head_cur != soa_pkg::LINK_NULL) begin
                  p_ff <= head_cur[PW-1:0];
                  state_ff <= S_META_CAP;
               end else if (!free_found) begin
                  res_status_ff <= soa_pkg::STATUS_NO_PAGE;
                  state_ff <= S_DONE;
               end else begin
                  // take a fresh page and make it the list head
                  p_ff <= free_page;
                  busy_ff[free_page] <= 1'b1;
                  head_ff[cls_ff] <= {1'b0, free_page};
                  used_ff <= '0;
                  guess_ff <= '0;
                  pr_ff <= soa_pkg::LINK_NULL;
                  nx_ff <= soa_pkg::LINK_NULL;
                  clr_ff <= '0;
                  state_ff <= S_NEWPG;
               end
            end
            S_NEWPG: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == WORD_W_L'(soa_pkg::WORDS - 1)) state_ff <= S_SCAN_INIT;
            end
            S_META_CAP: begin
               used_ff <= cnt_q[CNT_W-1 -: SW];
               guess_ff <= cnt_q[CNT_W-SW-1 -: SW];
               pr_ff <= prev_q;
               nx_ff <= next_q;
               state_ff <= S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
               w_ff <= start_guess[SW-1:6];
               lo_ff <= start_guess[5:0];
               k_ff <= '0;
               first_ff <= 1'b1;
               state_ff <= S_SCAN_RD;
            end
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (word_found) begin
                  slot_ff <= scan_slot;
                  word_ff <= bm_q | (64'd1 << word_pos);
                  used_new_ff <= used_ff + 1'b1;
                  guess_new_ff <= scan_slot + 1'b1;
                  res_page_ff <= p_ff;
                  res_offset_ff <= prod[soa_pkg::OFFSET_W-1:0];
                  if ({1'b0, SW'(used_ff + 1'b1)} == items_ff
                      || (items_ff == IW'(soa_pkg::MAX_SLOTS) && SW'(used_ff + 1'b1) == '0))
                     op_ff <= soa_pkg::LINK_UNLINK;
                  else
                     op_ff <= soa_pkg::LINK_NONE;
                  state_ff <= S_COMMIT;
               end else if (5'(k_ff) == nw) begin
                  res_status_ff <= soa_pkg::STATUS_NO_PAGE;
                  state_ff <= S_DONE;
               end else begin
                  k_ff <= k_ff + 4'd1;
                  first_ff <= 1'b0;
                  w_ff <= (5'(w_ff) + 5'd1 == nw) ? '0 : w_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_FREE_WAIT: begin
               if (div_done) begin
                  p_ff <= pidx_ff;
                  used_ff <= cnt_q[CNT_W-1 -: SW];
                  pr_ff <= prev_q;
                  nx_ff <= next_q;
                  slot_ff <= div_quo[SW-1:0];
                  if (!busy_ff[pidx_ff] || cnt_q[soa_pkg::CLASS_W-1:0] != cls_ff
                      || off_ff >= 12'(soa_pkg::DATA_BYTES) || div_rem != '0
                      || div_quo >= 12'(items_ff)) begin
                     res_status_ff <= soa_pkg::STATUS_BAD_FREE;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_FREE_RD;
                  end
               end
            end
            S_FREE_RD: state_ff <= S_FREE_BIT;
            S_FREE_BIT: begin
               if (!bm_q[slot_ff[5:0]]) begin
                  res_status_ff <= soa_pkg::STATUS_BAD_FREE;
                  state_ff <= S_DONE;
               end else begin
                  word_ff <= bm_q & ~(64'd1 << slot_ff[5:0]);
                  used_new_ff <= used_ff - 1'b1;
                  guess_new_ff <= slot_ff;
                  if (SW'(used_ff - 1'b1) == '0)
                     op_ff <= soa_pkg::LINK_UNLINK;
                  else if ({1'b0, SW'(used_ff - 1'b1)} == items_ff - 1'b1)
                     op_ff <= soa_pkg::LINK_ADDHEAD;
                  else
                     op_ff <= soa_pkg::LINK_NONE;
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               h_ff <= head_cur;
               if (op_ff == soa_pkg::LINK_UNLINK) begin
                  if (head_cur == {1'b0, p_ff}) head_ff[cls_ff] <= nx_ff;
                  if (mode_ff) busy_ff[p_ff] <= 1'b0;
               end else if (op_ff == soa_pkg::LINK_ADDHEAD) begin
                  head_ff[cls_ff] <= {1'b0, p_ff};
               end
               state_ff <= (op_ff == soa_pkg::LINK_NONE) ? S_DONE : S_LINK;
            end
            S_LINK: state_ff <= S_DONE;
            S_DONE: begin
               // output register frees up as soon as the old word is taken
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp.status <= res_status_ff;
                  rsp.out_page <= res_page_ff;
                  rsp.out_offset <= res_offset_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
endmodule

// ===== sim/slab_object_allocator_top_tb.sv =====
// slab_object_allocator_top_tb: request/result checks of the slab object allocator
// depends on soa_pkg, soa_if and the slab_object_allocator_top rtl
module slab_object_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PAGES   = soa_pkg::NUM_PAGES;
   localparam int NUM_CLASSES = soa_pkg::NUM_CLASSES;
   localparam int MAX_SLOTS   = soa_pkg::MAX_SLOTS;
   localparam int DATA_BYTES  = soa_pkg::DATA_BYTES;
   localparam int STATUS_W    = soa_pkg::STATUS_W;
   localparam int PAGE_W      = soa_pkg::PAGE_W;
   localparam int OFFSET_W    = soa_pkg::OFFSET_W;
   localparam int SIZE_W      = soa_pkg::SIZE_W;
   localparam logic [STATUS_W-1:0] STATUS_OK       = soa_pkg::STATUS_OK;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = soa_pkg::STATUS_NO_PAGE;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = soa_pkg::STATUS_BAD_SIZE;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = soa_pkg::STATUS_BAD_FREE;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0] page;
      logic [OFFSET_W-1:0] offset;
   } alloc_result_type;

   typedef struct {
      logic [PAGE_W-1:0] page;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0] size;
   } live_obj_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   soa_req_if req ();
   soa_rsp_if rsp ();

   slab_object_allocator_top DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #4 clock = ~clock;

   // predictor state
   logic [MAX_SLOTS-1:0] bitmap_q [NUM_PAGES];
   int unsigned used_q [NUM_PAGES];
   int unsigned guess_q [NUM_PAGES];
   int unsigned next_q [NUM_PAGES];
   int unsigned prev_q [NUM_PAGES];
   int unsigned head_q [NUM_CLASSES];
   bit busy_q [NUM_PAGES];
   int unsigned class_q [NUM_PAGES];

   alloc_result_type pending_results [$];
   live_obj_type live_objs [$];
   int mismatches = 0;
   int results_seen = 0;
   int idle_pct = 38;
   int stall_cycles = 0;
   int n_alloc = 0, n_free = 0;

   function automatic void model_reset();
      for (int i = 0; i < NUM_PAGES; i++) begin
         bitmap_q[i] = '0; used_q[i] = 0; guess_q[i] = 0; busy_q[i] = 0;
         class_q[i] = 0; next_q[i] = NUM_PAGES; prev_q[i] = NUM_PAGES;
      end
      for (int c = 0; c < NUM_CLASSES; c++) head_q[c] = NUM_PAGES;
   endfunction

   function automatic void list_push(int unsigned p, int unsigned c);
      int unsigned h;
      h = head_q[c];
      next_q[p] = h; prev_q[p] = NUM_PAGES; head_q[c] = p;
      if (h < NUM_PAGES) prev_q[h] = p;
   endfunction

   function automatic void list_remove(int unsigned p, int unsigned c);
      int unsigned pr, nx;
      pr = prev_q[p]; nx = next_q[p];
      if (pr < NUM_PAGES) next_q[pr] = nx;
      if (nx < NUM_PAGES) prev_q[nx] = pr;
      if (head_q[c] == p) head_q[c] = nx;
      next_q[p] = NUM_PAGES; prev_q[p] = NUM_PAGES;
   endfunction

   function automatic alloc_result_type predict_slab(logic mode, logic [SIZE_W-1:0] size,
                                                     logic [PAGE_W-1:0] pidx,
                                                     logic [OFFSET_W-1:0] off);
      alloc_result_type r;
      int unsigned bytes, cls, items, p, i, slot;
      bit found;
      r = '0;
      bytes = (int'(size) + 7) & ~7;
      if (size == 0 || bytes / 8 > NUM_CLASSES) begin
         r.status = STATUS_BAD_SIZE; return r;
      end
      cls = bytes / 8 - 1;
      items = DATA_BYTES / bytes;
      if (items > MAX_SLOTS) items = MAX_SLOTS;
      if (items == 0) begin
         r.status = STATUS_BAD_SIZE; return r;
      end
      if (mode == MODE_ALLOC) begin
         p = head_q[cls];
         found = 0;
         if (p >= NUM_PAGES) begin
            for (p = 0; p < NUM_PAGES; p++) if (!busy_q[p]) break;
            if (p >= NUM_PAGES) begin
               r.status = STATUS_NO_PAGE; return r;
            end
            bitmap_q[p] = '0; used_q[p] = 0; guess_q[p] = 0;
            busy_q[p] = 1; class_q[p] = cls;
            list_push(p, cls);
         end
         i = guess_q[p];
         for (int cnt = 0; cnt < items; cnt++) begin
            i = i % items;
            if (!bitmap_q[p][i]) begin
               found = 1; break;
            end
            i++;
         end
         if (!found) begin
            r.status = STATUS_NO_PAGE; return r;
         end
         bitmap_q[p][i] = 1'b1;
         used_q[p] = (used_q[p] + 1) & 'h1FF;
         if (used_q[p] == items || (items == 512 && used_q[p] == 0)) list_remove(p, cls);
         guess_q[p] = (i + 1) & 'h1FF;
         r.page = p[PAGE_W-1:0];
         r.offset = OFFSET_W'(i * bytes);
         return r;
      end
      if (!busy_q[pidx] || class_q[pidx] != cls || off >= DATA_BYTES || off % bytes != 0) begin
         r.status = STATUS_BAD_FREE; return r;
      end
      slot = off / bytes;
      if (slot >= items || !bitmap_q[pidx][slot]) begin
         r.status = STATUS_BAD_FREE; return r;
      end
      bitmap_q[pidx][slot] = 1'b0;
      used_q[pidx] = (used_q[pidx] - 1) & 'h1FF;
      guess_q[pidx] = slot;
      if (used_q[pidx] == 0) begin
         list_remove(pidx, cls);
         busy_q[pidx] = 0;
      end else if (used_q[pidx] == items - 1) begin
         list_push(pidx, cls);
      end
      return r;
   endfunction

   initial begin
      req.valid = 1'b0; req.mode = MODE_ALLOC; req.size_bytes = '0;
      req.page_index = '0; req.byte_offset = '0;
      rsp.ready = 1'b0;
   end

   // sends one word and predicts its result at acceptance
   task automatic send_req(logic mode, logic [SIZE_W-1:0] size,
                           logic [PAGE_W-1:0] pidx, logic [OFFSET_W-1:0] off);
      alloc_result_type r;
      logic acc;
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1; req.mode <= mode; req.size_bytes <= size;
      req.page_index <= pidx; req.byte_offset <= off;
      // ready follows registered state only, so it is settled by the falling edge
      do begin
         @(negedge clock);
         acc = req.ready;
         @(posedge clock);
      end while (!acc);
      r = predict_slab(mode, size, pidx, off);
      pending_results.push_back(r);
      if (mode == MODE_ALLOC && r.status == STATUS_OK)
         live_objs.push_back('{r.page, r.offset, size});
      if (mode == MODE_ALLOC) n_alloc++; else n_free++;
   endtask

   task automatic free_live(int idx);
      live_obj_type o;
      o = live_objs[idx];
      live_objs.delete(idx);
      send_req(MODE_FREE, o.size, o.page, o.offset);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      alloc_result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %h", rsp.status);
            end else begin
               e = pending_results.pop_front();
               if (rsp.status !== e.status || rsp.out_page !== e.page ||
                   rsp.out_offset !== e.offset) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st %0d pg %0d off %0d, got st %0d pg %0d off %0d",
                              e.status, e.page, e.offset, rsp.status, rsp.out_page,
                              rsp.out_offset);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      send_req(MODE_ALLOC, 8'd0, 6'd0, 12'd0);       // zero size
      send_req(MODE_ALLOC, 8'd201, 6'd0, 12'd0);     // above largest class
      send_req(MODE_FREE, 8'd255, 6'd63, 12'hFFF);
      send_req(MODE_ALLOC, 8'd1, 6'd63, 12'hFFF);
      send_req(MODE_ALLOC, 8'd200, 6'd0, 12'd0);
      send_req(MODE_ALLOC, 8'd200, 6'd0, 12'd0);
      send_req(MODE_FREE, 8'd200, 6'd1, 12'd200);    // page 1 holds class 24
      send_req(MODE_FREE, 8'd200, 6'd1, 12'd200);    // double free
      send_req(MODE_FREE, 8'd200, 6'd1, 12'd100);    // misaligned
      send_req(MODE_FREE, 8'd8, 6'd1, 12'd0);        // wrong class
      send_req(MODE_FREE, 8'd200, 6'd1, 12'd4000);   // past data area
      send_req(MODE_FREE, 8'd8, 6'd40, 12'd0);       // page not busy
      send_req(MODE_FREE, 8'd200, 6'd1, 12'd3800);   // slot never taken
      send_req(MODE_FREE, 8'd1, 6'd0, 12'd0);        // page 0 holds class 0
      send_req(MODE_FREE, 8'd200, 6'd2, 12'd0);      // page never taken
      while (live_objs.size() != 0) free_live(0);
      drain();
   endtask

   // fill one class-24 page to full and release it, exercising full page unlink and relink
   task automatic test_full_page();
      for (int k = 0; k < 21; k++) send_req(MODE_ALLOC, 8'd193, 6'd0, 12'd0);
      free_live(5);
      send_req(MODE_ALLOC, 8'd200, 6'd0, 12'd0);
      while (live_objs.size() != 0) free_live($urandom_range(live_objs.size() - 1));
      drain();
   endtask

   // run the 500-slot class past one page, then stack large pages behind it
   task automatic test_pool_fill();
      for (int k = 0; k < 505; k++)
         send_req(MODE_ALLOC, 8'($urandom_range(8, 1)), 6'd0, 12'd0);
      for (int k = 0; k < 40; k++) send_req(MODE_ALLOC, 8'd200, 6'd0, 12'd0);
      drain();   // sender waits for every result
   endtask

   task automatic test_random(int count);
      int sel;
      logic [OFFSET_W-1:0] off;
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) idle_pct = 0;
         if (k == count / 2 + 150) idle_pct = 38;
         sel = $urandom_range(99);
         if (sel < 50 || live_objs.size() == 0)
            send_req(MODE_ALLOC, 8'($urandom_range(200, 1)), 6'($urandom), 12'($urandom));
         else if (sel < 88)
            free_live($urandom_range(live_objs.size() - 1));
         else if (sel < 94) begin
            off = 12'($urandom);
            send_req(MODE_FREE, 8'($urandom), 6'($urandom), off);
         end else
            send_req(MODE_ALLOC, 8'($urandom), 6'($urandom), 12'($urandom));
      end
      drain();
   endtask

   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_page();
      test_pool_fill();
      test_random(540);
      repeat (60) @(posedge clock);
      $display("covered %0d allocates and %0d frees, %0d results checked",
               n_alloc, n_free, results_seen);
      $display("size and free errors, full page relink, multi-page class fill, random mix");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== slab_object_allocator_top.f =====
hdl/soa_pkg.sv
hdl/soa_if.sv
hdl/soa_div.sv
hdl/slab_object_allocator_top.sv
sim/slab_object_allocator_top_tb.sv
